FILE: hdl/kfl_pkg.sv
// ----------------------------------------------------------------------------
// kfl_pkg
// Types, codes and constants shared by the key state frame latch modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kfl_pkg;

  localparam int NUM_KEYS_DEF = 128;
  localparam int KEY_W        = 8;
  localparam int REG_W        = 7;
  localparam int WHEEL_W      = 16;
  localparam int FLAG_W       = 4;

  // Item modes.
  localparam logic [1:0] MODE_EVENT = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_WHEEL_UP   = 1'b0;
  localparam logic CFG_WHEEL_DOWN = 1'b1;

  // Flag bit positions.
  localparam int FL_REAL  = 0;
  localparam int FL_DELAY = 1;
  localparam int FL_CUR   = 2;
  localparam int FL_LAST  = 3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key_index;
    logic             is_down;
  } kfl_in_t;

  typedef struct packed {
    logic                      key_on;
    logic                      key_pressed;
    logic                      key_released;
    logic signed [WHEEL_W-1:0] frame_wheel;
  } kfl_out_t;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [KEY_W-1:0]  waddr;
    logic [FLAG_W-1:0] wdata;
    logic [KEY_W-1:0]  raddr;
  } kfl_mem_ctl_t;

  typedef enum logic [1:0] {
    FU_DOWN,
    FU_UP,
    FU_ADVANCE
  } kfl_fu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EV_RD,
    S_EV_WR,
    S_TICK,
    S_CLR,
    S_RPT_RD,
    S_RPT
  } kfl_state_t;

endpackage

`default_nettype wire

FILE: hdl/kfl_flag_mem.sv
// ----------------------------------------------------------------------------
// kfl_flag_mem
// Per-key flag memory with one write and one registered read port. Valid
// bits make a never-written or cleared entry read as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kfl_flag_mem #(
  parameter int NUM_KEYS = kfl_pkg::NUM_KEYS_DEF,
  parameter int AW       = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire kfl_pkg::kfl_mem_ctl_t         ctl,
  output logic [kfl_pkg::FLAG_W-1:0]         rd_flags
);
  import kfl_pkg::*;

  logic [FLAG_W-1:0] mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] vld_r;
  logic [FLAG_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr[AW-1:0]] <= ctl.wdata;
    end
    rd_data_r <= mem[ctl.raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.we) begin
        vld_r[ctl.waddr[AW-1:0]] <= 1'b1;
      end
      rd_vld_r <= vld_r[ctl.raddr[AW-1:0]];
    end
  end

  assign rd_flags = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

FILE: hdl/kfl_flag_unit.sv
// ----------------------------------------------------------------------------
// kfl_flag_unit
// Shared flag update unit: applies a key down, a key up or a frame advance
// to one entry's flags.
// ----------------------------------------------------------------------------
`default_nettype none

module kfl_flag_unit (
  input  wire kfl_pkg::kfl_fu_op_t          op,
  input  wire logic [kfl_pkg::FLAG_W-1:0]   flags_in,
  input  wire logic                         clr_real,
  output logic [kfl_pkg::FLAG_W-1:0]        flags_out,
  output logic                              on
);
  import kfl_pkg::*;

  logic real_q;

  always_comb begin
    real_q    = flags_in[FL_REAL] & ~clr_real;
    on        = real_q | flags_in[FL_DELAY];
    flags_out = flags_in;
    case (op)
      FU_DOWN: begin
        flags_out[FL_REAL]  = 1'b1;
        flags_out[FL_DELAY] = 1'b1;
      end
      FU_UP: begin
        flags_out[FL_REAL] = 1'b0;
      end
      FU_ADVANCE: begin
        flags_out[FL_REAL]  = real_q;
        flags_out[FL_DELAY] = 1'b0;
        flags_out[FL_CUR]   = on;
        flags_out[FL_LAST]  = flags_in[FL_CUR];
      end
      default: begin
        flags_out = flags_in;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/key_state_frame_latch.sv
// Key event: read, modify and write back, re-read, then the result is registered (states
// EV_RD, EV_WR, RPT_RD, RPT). Frame tick: sweeps the flag memory, one key a cycle.
// Clear: clears the flag memory, then reports; mode 3 and key events outside the key range
// go straight to the report. One item at a time, the next one taken in the cycle after its
// result loads, even while it still waits. Reset (synchronous, rst_n low) zeroes all flags
// via valid bits and both wheel values, and loads the wheel keys with 126 and 127.
// ----------------------------------------------------------------------------
// key_state_frame_latch
// Latches key down/up events into per-key real, delayed, current and last
// flags, advances them on a frame tick and tracks a wrapping wheel count.
// ----------------------------------------------------------------------------
`default_nettype none

module key_state_frame_latch #(
  parameter int NUM_KEYS = kfl_pkg::NUM_KEYS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire kfl_pkg::kfl_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output kfl_pkg::kfl_out_t               out_data,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [kfl_pkg::REG_W-1:0]  cfg_wdata
);
  import kfl_pkg::*;

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = $clog2(NUM_KEYS + 1);

  kfl_state_t state_r, state_nxt;
  kfl_in_t    item_r, item_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cnt_m1;
  logic       any_acc_r, any_acc_nxt;
  logic       any_cur_r, any_cur_nxt;
  logic       any_last_r, any_last_nxt;
  logic [WHEEL_W-1:0] pend_r, pend_nxt;
  logic [WHEEL_W-1:0] latch_r, latch_nxt;
  logic [REG_W-1:0]   up_key_r, down_key_r;
  logic       out_valid_r, out_valid_nxt;
  kfl_out_t   out_r, out_nxt;

  kfl_mem_ctl_t      mem_ctl;
  logic [FLAG_W-1:0] rd_flags;
  kfl_fu_op_t        fu_op;
  logic              fu_clr_real;
  logic [FLAG_W-1:0] fu_flags;
  logic              fu_on;
  logic [KEY_W-1:0]  sweep_key;
  logic              key_in_range;
  logic [FLAG_W-1:0] rpt_flags;

  kfl_flag_mem #(
    .NUM_KEYS (NUM_KEYS),
    .AW       (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .rd_flags (rd_flags)
  );

  kfl_flag_unit u_fu (
    .op        (fu_op),
    .flags_in  (rd_flags),
    .clr_real  (fu_clr_real),
    .flags_out (fu_flags),
    .on        (fu_on)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_key_r   <= REG_W'(126);
      down_key_r <= REG_W'(127);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHEEL_UP:   up_key_r   <= cfg_wdata;
        CFG_WHEEL_DOWN: down_key_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      any_acc_r   <= 1'b0;
      any_cur_r   <= 1'b0;
      any_last_r  <= 1'b0;
      pend_r      <= '0;
      latch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      any_acc_r   <= any_acc_nxt;
      any_cur_r   <= any_cur_nxt;
      any_last_r  <= any_last_nxt;
      pend_r      <= pend_nxt;
      latch_r     <= latch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign cnt_m1       = cnt_r - CW'(1);
  assign sweep_key    = KEY_W'(cnt_m1);
  assign key_in_range = item_r.key_index < KEY_W'(NUM_KEYS);

  always_comb begin
    if (key_in_range) begin
      rpt_flags = rd_flags;
    end else if (item_r.key_index == KEY_W'(NUM_KEYS)) begin
      rpt_flags = '0;
      rpt_flags[FL_CUR]  = any_cur_r;
      rpt_flags[FL_LAST] = any_last_r;
    end else begin
      rpt_flags = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    any_acc_nxt   = any_acc_r;
    any_cur_nxt   = any_cur_r;
    any_last_nxt  = any_last_r;
    pend_nxt      = pend_r;
    latch_nxt     = latch_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    in_stall      = 1'b1;
    fu_op         = FU_ADVANCE;
    fu_clr_real   = 1'b0;
    mem_ctl       = '0;
    mem_ctl.raddr = item_r.key_index;
    mem_ctl.waddr = item_r.key_index;
    mem_ctl.wdata = fu_flags;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.mode == MODE_EVENT && in_data.key_index < KEY_W'(NUM_KEYS)) begin
            state_nxt = S_EV_RD;
          end else if (in_data.mode == MODE_TICK) begin
            state_nxt   = S_TICK;
            cnt_nxt     = '0;
            any_acc_nxt = 1'b0;
          end else if (in_data.mode == MODE_CLEAR) begin
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_RPT_RD;
          end
        end
      end
      S_EV_RD: begin
        state_nxt = S_EV_WR;
      end
      S_EV_WR: begin
        fu_op      = item_r.is_down ? FU_DOWN : FU_UP;
        mem_ctl.we = 1'b1;
        if (item_r.is_down) begin
          if (item_r.key_index == {1'b0, up_key_r}) begin
            pend_nxt = pend_r + WHEEL_W'(1);
          end else if (item_r.key_index == {1'b0, down_key_r}) begin
            pend_nxt = pend_r - WHEEL_W'(1);
          end
        end
        state_nxt = S_RPT_RD;
      end
      S_TICK: begin
        // Read entry cnt while entry cnt-1, read last cycle, is written back.
        mem_ctl.raddr = KEY_W'(cnt_r);
        mem_ctl.waddr = sweep_key;
        fu_clr_real   = (sweep_key == {1'b0, up_key_r}) ||
                        (sweep_key == {1'b0, down_key_r});
        cnt_nxt       = cnt_r + CW'(1);
        if (cnt_r != '0) begin
          mem_ctl.we  = 1'b1;
          any_acc_nxt = any_acc_r | fu_on;
        end
        if (cnt_r == CW'(NUM_KEYS)) begin
          any_cur_nxt  = any_acc_r | fu_on;
          any_last_nxt = any_cur_r;
          latch_nxt    = pend_r;
          pend_nxt     = '0;
          state_nxt    = S_RPT_RD;
        end
      end
      S_CLR: begin
        mem_ctl.clr  = 1'b1;
        any_cur_nxt  = 1'b0;
        any_last_nxt = 1'b0;
        pend_nxt     = '0;
        latch_nxt    = '0;
        state_nxt    = S_RPT_RD;
      end
      S_RPT_RD: begin
        state_nxt = S_RPT;
      end
      S_RPT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.key_on       = rpt_flags[FL_CUR];
          out_nxt.key_pressed  = rpt_flags[FL_CUR] & ~rpt_flags[FL_LAST];
          out_nxt.key_released = ~rpt_flags[FL_CUR] & rpt_flags[FL_LAST];
          out_nxt.frame_wheel  = latch_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: hdl/kfl_checker.sv
// ----------------------------------------------------------------------------
// kfl_checker
// Port-level checks for the key state frame latch, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kfl_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire kfl_pkg::kfl_out_t          out_data
);
  import kfl_pkg::*;

  // An accepted item keeps the block busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took an item while still working on the previous one");

  // A new result only follows a period in which the block was busy.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without any work");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind key_state_frame_latch kfl_checker u_kfl_checker (.*);

`default_nettype wire
